// ===== rtl/core/dash_dda_pkg.sv =====
// ----------------------------------------------------------------------------
// dash_dda_pkg
// Shared types and constants of the dashed DDA line rasterizer.
// ----------------------------------------------------------------------------
package dash_dda_pkg;

  // field widths
  localparam int COORD_W   = 9;
  localparam int PATTERN_W = 6;
  localparam int PHASE_W   = 3;
  localparam int PIX_W     = 8;

  // image and dash pattern geometry
  localparam int IMAGE_SIZE    = 512;
  localparam int PATTERN_LEN   = 6;
  localparam int FRAC_BITS_DEF = 16;

  // largest coordinate that can be emitted
  localparam logic [COORD_W-1:0] COORD_MAX =
    (IMAGE_SIZE > (1 << COORD_W)) ? {COORD_W{1'b1}} : COORD_W'(IMAGE_SIZE - 1);

  localparam logic [PATTERN_W-1:0] DASH_RESET = PATTERN_W'(27);
  localparam logic [PHASE_W-1:0]   PHASE_LAST = PHASE_W'(PATTERN_LEN - 1);

  // gray values
  localparam logic [PIX_W-1:0] PIX_DARK  = PIX_W'(0);
  localparam logic [PIX_W-1:0] PIX_WHITE = PIX_W'(255);

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [PIX_W-1:0]   pixel_value;
    logic               line_done;
  } out_item_t;

endpackage

// ===== rtl/core/dashed_dda_line_raster_top.sv =====
// ----------------------------------------------------------------------------
// dashed_dda_line_raster_top
// Dashed DDA line rasterizer with a serial fixed-point divider.
// ----------------------------------------------------------------------------
// A load item emits the start pixel (dark) at once and then sets up the
// line: the minor and major increments are found by one shared restoring
// divider, one quotient bit per cycle, x first and then y, so a load keeps
// in_ready low until both divisions are done; a zero-length line needs no
// division. Step items are taken one per cycle while the output is not
// stalled, each giving one pixel through a single output register, and a
// step item with no line in progress is taken and dropped. Endpoints above
// IMAGE_SIZE-1 are clamped. The dash pattern register may be written only
// while no item is in flight.
module dashed_dda_line_raster_top #(
  parameter int FRAC_BITS = dash_dda_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  dash_dda_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output dash_dda_pkg::out_item_t                out_item,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dash_dda_pkg::PATTERN_W-1:0]     cfg_dash_pattern
);
  import dash_dda_pkg::*;

  localparam int POS_W = COORD_W + FRAC_BITS;
  localparam int INC_W = FRAC_BITS + 2;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);
  localparam logic [POS_W:0]   HALF_FX  = (POS_W + 1)'(1) << (FRAC_BITS - 1);

  typedef enum logic {S_IDLE, S_DIV} state_t;

  state_t                 state_r, state_nxt;
  logic [PATTERN_W-1:0]   dash_pattern_r;
  logic [POS_W-1:0]       x_pos_r, x_pos_nxt, y_pos_r, y_pos_nxt;
  logic [INC_W-1:0]       x_inc_r, x_inc_nxt, y_inc_r, y_inc_nxt;
  logic [COORD_W-1:0]     steps_left_r, steps_left_nxt;
  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [COORD_W-1:0]     y_mag_r, y_mag_nxt;
  logic                   x_neg_r, x_neg_nxt, y_neg_r, y_neg_nxt;
  logic [COORD_W:0]       div_rem_r, div_rem_nxt;
  logic [Q_W-1:0]         div_q_r, div_q_nxt;
  logic [CNT_W-1:0]       div_cnt_r, div_cnt_nxt;
  logic                   div_axis_r, div_axis_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic                   in_fire, out_fire;
  logic [COORD_W-1:0]     xs, ys, xe, ye, adx, ady, steps;
  logic                   xneg, yneg;
  logic                   div_ge;
  logic [COORD_W:0]       div_diff;
  logic [Q_W-1:0]         div_q_fin;
  logic [INC_W-1:0]       div_inc;
  logic [POS_W-1:0]       x_adv, y_adv;
  logic [COORD_W-1:0]     x_pix, y_pix;
  logic [PATTERN_W+1:0]   pattern_ext;
  logic                   step_emit;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
    return (c > COORD_MAX) ? COORD_MAX : c;
  endfunction

  function automatic logic [COORD_W-1:0] round_pos(input logic [POS_W-1:0] p);
    logic [POS_W:0] s;
    s = {1'b0, p} + HALF_FX;
    return clamp_coord(s[FRAC_BITS +: COORD_W]);
  endfunction

  // handshakes
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // load setup: clamped endpoints, deltas, step count
  always_comb begin
    xs    = clamp_coord(in_item.x_start);
    ys    = clamp_coord(in_item.y_start);
    xe    = clamp_coord(in_item.x_end);
    ye    = clamp_coord(in_item.y_end);
    xneg  = xe < xs;
    yneg  = ye < ys;
    adx   = xneg ? xs - xe : xe - xs;
    ady   = yneg ? ys - ye : ye - ys;
    steps = (adx > ady) ? adx : ady;
  end

  // shared divider step: one quotient bit per cycle
  always_comb begin
    div_ge    = div_rem_r >= {1'b0, steps_left_r};
    div_diff  = div_ge ? div_rem_r - {1'b0, steps_left_r} : div_rem_r;
    div_q_fin = {div_q_r[Q_W-2:0], div_ge};
    if ((div_axis_r ? y_neg_r : x_neg_r)) begin
      div_inc = INC_W'(0) - {1'b0, div_q_fin};
    end else begin
      div_inc = {1'b0, div_q_fin};
    end
  end

  // step datapath: advance both positions and round
  always_comb begin
    x_adv       = x_pos_r + {{(POS_W-INC_W){x_inc_r[INC_W-1]}}, x_inc_r};
    y_adv       = y_pos_r + {{(POS_W-INC_W){y_inc_r[INC_W-1]}}, y_inc_r};
    x_pix       = round_pos(x_adv);
    y_pix       = round_pos(y_adv);
    pattern_ext = {2'b00, dash_pattern_r};
    step_emit   = in_fire && (in_item.opcode == OP_STEP) && (steps_left_r != '0);
  end

  // next state
  always_comb begin
    state_nxt      = state_r;
    x_pos_nxt      = x_pos_r;
    y_pos_nxt      = y_pos_r;
    x_inc_nxt      = x_inc_r;
    y_inc_nxt      = y_inc_r;
    steps_left_nxt = steps_left_r;
    phase_nxt      = phase_r;
    y_mag_nxt      = y_mag_r;
    x_neg_nxt      = x_neg_r;
    y_neg_nxt      = y_neg_r;
    div_rem_nxt    = div_rem_r;
    div_q_nxt      = div_q_r;
    div_cnt_nxt    = div_cnt_r;
    div_axis_nxt   = div_axis_r;
    out_valid_nxt  = out_fire ? 1'b0 : out_valid_r;
    out_item_nxt   = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_item.opcode == OP_LOAD)) begin
          x_pos_nxt      = {xs, {FRAC_BITS{1'b0}}};
          y_pos_nxt      = {ys, {FRAC_BITS{1'b0}}};
          phase_nxt      = '0;
          steps_left_nxt = steps;
          x_inc_nxt      = '0;
          y_inc_nxt      = '0;
          y_mag_nxt      = ady;
          x_neg_nxt      = xneg;
          y_neg_nxt      = yneg;
          div_rem_nxt    = {1'b0, adx};
          div_cnt_nxt    = '0;
          div_axis_nxt   = 1'b0;
          if (steps != '0) begin
            state_nxt = S_DIV;
          end
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{pixel_x: xs, pixel_y: ys, pixel_value: PIX_DARK,
                            line_done: (steps == '0)};
        end else if (step_emit) begin
          x_pos_nxt      = x_adv;
          y_pos_nxt      = y_adv;
          steps_left_nxt = steps_left_r - COORD_W'(1);
          phase_nxt      = (phase_r >= PHASE_LAST) ? '0 : phase_r + PHASE_W'(1);
          out_valid_nxt  = 1'b1;
          out_item_nxt   = '{pixel_x: x_pix, pixel_y: y_pix,
                             pixel_value: pattern_ext[phase_r] ? PIX_DARK : PIX_WHITE,
                             line_done: (steps_left_r == COORD_W'(1))};
        end
      end
      S_DIV: begin
        div_q_nxt   = div_q_fin;
        div_rem_nxt = {div_diff[COORD_W-1:0], 1'b0};
        div_cnt_nxt = div_cnt_r + CNT_W'(1);
        if (div_cnt_r == CNT_LAST) begin
          div_cnt_nxt = '0;
          if (!div_axis_r) begin
            x_inc_nxt    = div_inc;
            div_axis_nxt = 1'b1;
            div_rem_nxt  = {1'b0, y_mag_r};
          end else begin
            y_inc_nxt = div_inc;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      dash_pattern_r <= DASH_RESET;
      x_pos_r        <= '0;
      y_pos_r        <= '0;
      x_inc_r        <= '0;
      y_inc_r        <= '0;
      steps_left_r   <= '0;
      phase_r        <= '0;
      div_cnt_r      <= '0;
      div_axis_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        dash_pattern_r <= cfg_dash_pattern;
      end
      x_pos_r        <= x_pos_nxt;
      y_pos_r        <= y_pos_nxt;
      x_inc_r        <= x_inc_nxt;
      y_inc_r        <= y_inc_nxt;
      steps_left_r   <= steps_left_nxt;
      phase_r        <= phase_nxt;
      div_cnt_r      <= div_cnt_nxt;
      div_axis_r     <= div_axis_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    y_mag_r    <= y_mag_nxt;
    x_neg_r    <= x_neg_nxt;
    y_neg_r    <= y_neg_nxt;
    div_rem_r  <= div_rem_nxt;
    div_q_r    <= div_q_nxt;
    out_item_r <= out_item_nxt;
  end

  // checks
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_item.opcode == OP_LOAD) && (steps != '0)) |=> !in_ready)
    else $error("load with nonzero length did not start division");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (steps_left_r != '0))
    else $error("division running with zero step count");

  a_div_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> ($stable(steps_left_r) && $stable(x_pos_r)))
    else $error("line state changed during division");

  a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (step_emit && (steps_left_r == COORD_W'(1))) |=> (out_valid && out_item.line_done))
    else $error("final pixel not flagged");

endmodule

// ===== dv/tb_dashed_dda_line_raster_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dashed_dda_line_raster_top
// Self-checking bench for the dashed DDA line rasterizer.
// ----------------------------------------------------------------------------
// Line commands are queued by the stimulus process and fed to the block by a
// bursty driver. Every accepted item runs through a bit-accurate line walker
// that queues any pixel it should produce. A stalling monitor pops and checks
// each pixel field by field. The dash pattern is changed between phases,
// only after the block has drained and finished its divide.
// ----------------------------------------------------------------------------
module tb_dashed_dda_line_raster_top;
  import dash_dda_pkg::*;

  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int POS_W = COORD_W + FRAC;
  localparam int INC_W = FRAC + 2;
  // time for both divides, plus margin
  localparam int SETTLE_CYCLES = 2 * (FRAC + 1) + 16;
  localparam int PHASES        = 5;
  localparam int PHASE_PIXELS  = 100;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  in_item_t             in_item          = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [PATTERN_W-1:0] cfg_dash_pattern = '0;

  dashed_dda_line_raster_top #(.FRAC_BITS(FRAC)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_dash_pattern (cfg_dash_pattern)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // commands waiting to be driven and pixels waiting to come out
  in_item_t  raster_cmds[$];
  out_item_t pixels_due[$];

  // line walker state, mirrors the block after reset
  logic [PATTERN_W-1:0] dash_pat   = DASH_RESET;
  logic [POS_W-1:0]     walk_x     = '0;
  logic [POS_W-1:0]     walk_y     = '0;
  logic [INC_W-1:0]     inc_x      = '0;
  logic [INC_W-1:0]     inc_y      = '0;
  logic [9:0]           steps_left = '0;
  logic [PHASE_W-1:0]   dash_phase = '0;

  int errors         = 0;
  int loads_taken    = 0;
  int steps_taken    = 0;
  int pixels_checked = 0;
  int dash_writes    = 0;

  function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] c);
    return (c > COORD_MAX) ? COORD_MAX : c;
  endfunction

  // |to-from| * 2^FRAC / steps truncated, sign applied afterwards
  function automatic logic [INC_W-1:0] minor_increment(logic [COORD_W-1:0] from,
                                                       logic [COORD_W-1:0] to,
                                                       logic [9:0] steps);
    logic [COORD_W-1:0] mag;
    logic [POS_W-1:0]   num;
    logic [INC_W-1:0]   q;
    mag = (to >= from) ? to - from : from - to;
    num = POS_W'(mag) << FRAC;
    q   = INC_W'(num / POS_W'(steps));
    if (to < from) q = -q;
    return q;
  endfunction

  // position rounded to the nearest pixel
  function automatic logic [COORD_W-1:0] pixel_of(logic [POS_W-1:0] pos);
    logic [POS_W:0] r;
    r = (POS_W+1)'(pos) + (POS_W+1)'(1 << (FRAC - 1));
    return clamp_coord(r[FRAC +: COORD_W]);
  endfunction

  // advance the line walker by one accepted item
  function automatic void trace_line_item(in_item_t it);
    out_item_t          px;
    logic [COORD_W-1:0] xs, ys, xe, ye;
    logic [9:0]         adx, ady, steps;
    if (it.opcode == OP_LOAD) begin
      loads_taken++;
      xs = clamp_coord(it.x_start);
      ys = clamp_coord(it.y_start);
      xe = clamp_coord(it.x_end);
      ye = clamp_coord(it.y_end);
      adx = (xe >= xs) ? 10'(xe - xs) : 10'(xs - xe);
      ady = (ye >= ys) ? 10'(ye - ys) : 10'(ys - ye);
      steps = (adx > ady) ? adx : ady;
      walk_x     = POS_W'(xs) << FRAC;
      walk_y     = POS_W'(ys) << FRAC;
      dash_phase = '0;
      steps_left = steps;
      inc_x = (steps != 0) ? minor_increment(xs, xe, steps) : '0;
      inc_y = (steps != 0) ? minor_increment(ys, ye, steps) : '0;
      px.pixel_x     = xs;
      px.pixel_y     = ys;
      px.pixel_value = PIX_DARK;
      px.line_done   = (steps == 0);
      pixels_due.push_back(px);
    end else begin
      steps_taken++;
      // a step with no line in progress is dropped
      if (steps_left != 0) begin
        walk_x = walk_x + POS_W'($signed(inc_x));
        walk_y = walk_y + POS_W'($signed(inc_y));
        px.pixel_x = pixel_of(walk_x);
        px.pixel_y = pixel_of(walk_y);
        // phases past the register width read as white
        px.pixel_value = (dash_phase < PATTERN_W && dash_pat[dash_phase]) ?
                         PIX_DARK : PIX_WHITE;
        steps_left   = steps_left - 1'b1;
        px.line_done = (steps_left == 0);
        dash_phase   = dash_phase + 1'b1;
        if (dash_phase >= PATTERN_LEN) dash_phase = '0;
        pixels_due.push_back(px);
      end
    end
  endfunction

  // driver: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) trace_line_item(in_item);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (raster_cmds.size() != 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          in_item  <= raster_cmds.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each pixel, then pick the next ready level
  rx_mode_e  rx_mode     = RX_OPEN;
  int        rx_mode_left = 0;
  int        sparse_cnt  = 0;
  out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixels_due.size() == 0) begin
          $error("pixel with none pending: x=%0d y=%0d value=%0d done=%0d",
                 out_item.pixel_x, out_item.pixel_y, out_item.pixel_value,
                 out_item.line_done);
          errors++;
        end else begin
          want = pixels_due.pop_front();
          pixels_checked++;
          if (out_item.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, out_item.pixel_x);
            errors++;
          end
          if (out_item.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, out_item.pixel_y);
            errors++;
          end
          if (out_item.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %0d, got %0d",
                   want.pixel_value, out_item.pixel_value);
            errors++;
          end
          if (out_item.line_done !== want.line_done) begin
            $error("line_done: expected %0d, got %0d",
                   want.line_done, out_item.line_done);
            errors++;
          end
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready  <= (sparse_cnt == 0);
          sparse_cnt = (sparse_cnt + 1) % 4;
        end
      endcase
    end
  end

  task automatic push_cmd(logic op, logic [COORD_W-1:0] xs, logic [COORD_W-1:0] ys,
                          logic [COORD_W-1:0] xe, logic [COORD_W-1:0] ye);
    in_item_t it;
    it.opcode  = op;
    it.x_start = xs;
    it.y_start = ys;
    it.x_end   = xe;
    it.y_end   = ye;
    raster_cmds.push_back(it);
  endtask

  // step items carry random, ignored coordinates
  task automatic push_steps(int n);
    repeat (n)
      push_cmd(OP_STEP, COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom), COORD_W'($urandom));
  endtask

  function automatic logic [COORD_W-1:0] fit_coord(int c);
    if (c < 0) return '0;
    if (c > IMAGE_SIZE - 1) return COORD_W'(IMAGE_SIZE - 1);
    return COORD_W'(c);
  endfunction

  // one random line: mostly walked to the end, sometimes cut short,
  // sometimes followed by idle steps, now and then a stray item
  task automatic push_random_line(inout int produced);
    int                 r, span, dx, dy, n, k;
    logic [COORD_W-1:0] xs, ys, xe, ye;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      push_cmd(1'($urandom), COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom), COORD_W'($urandom));
      return;
    end
    span = ($urandom_range(0, 99) < 80) ? 24 :
           ($urandom_range(0, 99) < 85) ? 120 : IMAGE_SIZE - 1;
    xs = COORD_W'($urandom);
    ys = COORD_W'($urandom);
    dx = int'($urandom_range(0, 2 * span)) - span;
    dy = int'($urandom_range(0, 2 * span)) - span;
    xe = fit_coord(int'(xs) + dx);
    ye = fit_coord(int'(ys) + dy);
    dx = (xe >= xs) ? int'(xe - xs) : int'(xs - xe);
    dy = (ye >= ys) ? int'(ye - ys) : int'(ys - ye);
    n  = (dx > dy) ? dx : dy;
    push_cmd(OP_LOAD, xs, ys, xe, ye);
    k = (r < 12 && n > 0) ? $urandom_range(0, n - 1) : n;
    push_steps(k);
    produced += 1 + k;
    if (r >= 80) push_steps($urandom_range(1, 3));
  endtask

  // short directed opening: idle steps, zero-length lines, corners,
  // loads over a running line, diagonal, horizontal and vertical lines
  task automatic push_directed();
    push_steps(1);
    push_cmd(OP_LOAD, 9'd0, 9'd0, 9'd0, 9'd0);
    push_steps(1);
    push_cmd(OP_LOAD, 9'd511, 9'd511, 9'd511, 9'd511);
    push_cmd(OP_LOAD, 9'd0, 9'd0, 9'd511, 9'd511);
    push_steps(3);
    push_cmd(OP_LOAD, 9'd511, 9'd0, 9'd0, 9'd511);
    push_steps(3);
    push_cmd(OP_LOAD, 9'd5, 9'd5, 9'd8, 9'd2);
    push_steps(4);
    push_cmd(OP_LOAD, 9'd0, 9'd511, 9'd3, 9'd511);
    push_steps(3);
    push_cmd(OP_LOAD, 9'd200, 9'd100, 9'd200, 9'd103);
    push_steps(3);
  endtask

  task automatic wait_drained();
    while (raster_cmds.size() != 0 || in_valid || pixels_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_dash(logic [PATTERN_W-1:0] pat);
    cfg_dash_pattern <= pat;
    cfg_valid        <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dash_pat = pat;
    dash_writes++;
  endtask

  initial begin
    int                   produced;
    logic [PATTERN_W-1:0] pat;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    push_directed();
    for (int p = 0; p < PHASES; p++) begin
      // new dash pattern only once the block is drained and quiet
      if (p > 0) begin
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        pat = (p == 1) ? '0 : (p == 2) ? '1 : PATTERN_W'($urandom);
        write_dash(pat);
      end
      // one line across the whole image
      if (p == PHASES - 1) begin
        push_cmd(OP_LOAD, 9'd0, 9'd511, 9'd511, 9'd0);
        push_steps(IMAGE_SIZE - 1);
      end
      produced = 0;
      while (produced < PHASE_PIXELS) push_random_line(produced);
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d load and %0d step items driven, %0d pixels checked",
             loads_taken, steps_taken, pixels_checked);
    $display("%0d dash pattern writes over %0d phases", dash_writes, PHASES);
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("dashed_dda_line_raster_top test passed");
    end else begin
      $display("dashed_dda_line_raster_top test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("dashed_dda_line_raster_top test failed");
    $finish;
  end

endmodule
